/* rtl/core/lagged_fibonacci_generator_top_defines.svh */
// Assertion macros used by the lagged Fibonacci generator port checker.
`ifndef LAGGED_FIBONACCI_GENERATOR_TOP_DEFINES_SVH
`define LAGGED_FIBONACCI_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LFG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define LFG_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

/* rtl/core/lfg_pkg.sv */
// Package with constants, codes, command types and helper functions of the generator.
`default_nettype none
package lfg_pkg;

   localparam int MAX_LAG    = 64;
   localparam int VALUE_BITS = 16;
   localparam int PTR_BITS   = $clog2(MAX_LAG);
   localparam int LAG_W      = 7;
   localparam int MOD_W      = 16;
   localparam int OP_W       = 3;
   localparam int SEED_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 2 * VALUE_BITS;
   localparam int CNT_W      = $clog2(PROD_W + 1);

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_GENERATE = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_XOR
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAG_FIRST,
      CSR_LAG_SECOND,
      CSR_MODULUS,
      CSR_OPERATION
   } csr_idx_type;

   typedef struct packed {
      logic load_seed;
      logic rd_first;
      logic rd_second;
      logic cap_x;
      logic cap_y;
      logic prepare;
      logic red_step;
      logic push_result;
   } lfg_cmd_type;

   typedef struct packed {
      logic red_last;
   } lfg_status_type;

   // Lag of zero means the newest value; lags past the ring depth mean the oldest.
   function automatic logic [PTR_BITS:0] clamp_lag(input logic [LAG_W-1:0] lag);
      logic [PTR_BITS:0] d;
      if (lag == '0) begin
         d = (PTR_BITS + 1)'(1);
      end else if (int'(lag) > MAX_LAG) begin
         d = (PTR_BITS + 1)'(MAX_LAG);
      end else begin
         d = (PTR_BITS + 1)'(lag);
      end
      return d;
   endfunction

   function automatic logic [PTR_BITS-1:0] lag_addr(input logic [PTR_BITS-1:0] wp,
                                                    input logic [PTR_BITS:0] d);
      logic [PTR_BITS+1:0] w;
      logic [PTR_BITS+1:0] de;
      logic [PTR_BITS+1:0] s;
      w  = (PTR_BITS + 2)'(wp);
      de = (PTR_BITS + 2)'(d);
      if (w >= de) begin
         s = w - de;
      end else begin
         s = w + (PTR_BITS + 2)'(MAX_LAG) - de;
      end
      return s[PTR_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/lagged_fibonacci_generator_top.sv */
// Top level of the lagged Fibonacci generator: controller, datapath and ports.
//
//   Channel   Direction  Contents
//   req_*     in         tuser: func; tdata: seed_value
//   rsp_*     out        tdata: value, one transaction per generate item
//   csr_*     in         write enable, register index, write data
//
// A load writes the history and leaves the block idle; loads can arrive every cycle.
// A generate reads both lags, prepares the operation and runs the bit-serial modulo reducer.
// Reset clears the history through per-entry valid bits, so no clearing pass is needed.
// A finished result sits in the output register while the next item is accepted.
// A generate whose result finds that register still full waits in its last step.
`default_nettype none
module lagged_fibonacci_generator_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [lfg_pkg::SEED_W-1:0]     req_tdata,   // [15:0] seed_value
   input  wire logic                           req_tuser,   // [0] func
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [lfg_pkg::MOD_W-1:0]      rsp_tdata,   // [15:0] value
   input  wire logic                           csr_wr_en,
   input  wire logic [lfg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lfg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfg_pkg::*;

   lfg_cmd_type    cmd;
   lfg_status_type status;

   lfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .seed_value (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .value      (rsp_tdata)
   );

endmodule
`default_nettype wire

/* rtl/core/lfg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lfg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/lfg_datapath.sv */
// Datapath: configuration registers, history ring, operand capture and bit-serial reducer.
`default_nettype none
module lfg_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [lfg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lfg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [lfg_pkg::SEED_W-1:0]       seed_value,
   input  wire lfg_pkg::lfg_cmd_type             cmd,
   output lfg_pkg::lfg_status_type               status,
   output logic      [lfg_pkg::MOD_W-1:0]        value
);
   import lfg_pkg::*;

   logic [LAG_W-1:0]      lag_first_ff, lag_first_in;
   logic [LAG_W-1:0]      lag_second_ff, lag_second_in;
   logic [MOD_W-1:0]      modulus_ff, modulus_in;
   logic [OP_W-1:0]       operation_ff, operation_in;
   logic [PTR_BITS-1:0]   wp_ff, wp_in;
   logic [MAX_LAG-1:0]    valid_ff, valid_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [VALUE_BITS-1:0] x_ff, x_in;
   logic [VALUE_BITS-1:0] y_ff, y_in;
   logic                  neg_ff, neg_in;
   logic [PROD_W-1:0]     div_ff, div_in;
   logic [MOD_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MOD_W-1:0]      value_ff, value_in;

   logic                  push;
   logic [PTR_BITS-1:0]   rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;
   logic [VALUE_BITS-1:0] operand;
   logic [VALUE_BITS-1:0] wr_data;
   logic [MOD_W-1:0]      result;
   logic [MOD_W:0]        rem_shift;
   logic [MOD_W:0]        rem_diff;

   assign push    = cmd.load_seed | cmd.push_result;
   assign rd_addr = cmd.rd_second ? lag_addr(wp_ff, clamp_lag(lag_second_ff))
                                  : lag_addr(wp_ff, clamp_lag(lag_first_ff));
   assign wr_data = cmd.push_result ? VALUE_BITS'(result) : VALUE_BITS'(seed_value);
   assign operand = rd_vld_ff ? ram_rd_data : '0;

   assign rem_shift = {rem_ff, div_ff[PROD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, modulus_ff};

   always_comb begin
      if (modulus_ff == '0) begin
         result = '0;
      end else if (neg_ff && (rem_ff != '0)) begin
         result = modulus_ff - rem_ff;
      end else begin
         result = rem_ff;
      end
   end

   lfg_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_LAG)
   ) u_history (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_first | cmd.rd_second),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      lag_first_in  = lag_first_ff;
      lag_second_in = lag_second_ff;
      modulus_in    = modulus_ff;
      operation_in  = operation_ff;
      wp_in         = wp_ff;
      valid_in      = valid_ff;
      rd_vld_in     = rd_vld_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      neg_in        = neg_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      value_in      = value_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LAG_FIRST:  lag_first_in  = LAG_W'(csr_wdata);
            CSR_LAG_SECOND: lag_second_in = LAG_W'(csr_wdata);
            CSR_MODULUS:    modulus_in    = MOD_W'(csr_wdata);
            CSR_OPERATION:  operation_in  = OP_W'(csr_wdata);
         endcase
      end

      if (push) begin
         valid_in[wp_ff] = 1'b1;
         if (wp_ff == PTR_BITS'(MAX_LAG - 1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + PTR_BITS'(1);
         end
      end

      if (cmd.rd_first | cmd.rd_second) begin
         rd_vld_in = valid_ff[rd_addr];
      end
      if (cmd.cap_x) begin
         x_in = operand;
      end
      if (cmd.cap_y) begin
         y_in = operand;
      end

      if (cmd.prepare) begin
         rem_in = '0;
         cnt_in = CNT_W'(PROD_W);
         neg_in = 1'b0;
         case (operation_ff)
            OP_ADD: div_in = PROD_W'(x_ff) + PROD_W'(y_ff);
            OP_SUB: begin
               if (y_ff > x_ff) begin
                  neg_in = 1'b1;
                  div_in = PROD_W'(y_ff - x_ff);
               end else begin
                  div_in = PROD_W'(x_ff - y_ff);
               end
            end
            OP_MUL: div_in = PROD_W'(x_ff) * PROD_W'(y_ff);
            OP_XOR: div_in = PROD_W'(x_ff ^ y_ff);
            default: div_in = '0;
         endcase
      end

      if (cmd.red_step) begin
         div_in = {div_ff[PROD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (rem_shift >= {1'b0, modulus_ff}) begin
            rem_in = rem_diff[MOD_W-1:0];
         end else begin
            rem_in = rem_shift[MOD_W-1:0];
         end
      end

      if (cmd.push_result) begin
         value_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_first_ff  <= LAG_W'(1);
         lag_second_ff <= LAG_W'(2);
         modulus_ff    <= MOD_W'(65535);
         operation_ff  <= OP_ADD;
         wp_ff         <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
      end else begin
         lag_first_ff  <= lag_first_in;
         lag_second_ff <= lag_second_in;
         modulus_ff    <= modulus_in;
         operation_ff  <= operation_in;
         wp_ff         <= wp_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= rd_vld_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      neg_ff    <= neg_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      value_ff  <= value_in;
   end

   assign status.red_last = (cnt_ff == CNT_W'(1));
   assign value           = value_ff;

endmodule
`default_nettype wire

/* rtl/core/lfg_ctrl.sv */
// Controller state machine that sequences loads, operand reads, reduction and result hand-off.
`default_nettype none
module lfg_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tuser,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire lfg_pkg::lfg_status_type status,
   output lfg_pkg::lfg_cmd_type         cmd
);
   import lfg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_B,
      ST_CAPTURE_Y,
      ST_PREPARE,
      ST_REDUCE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == FUNC_GENERATE) begin
                  cmd.rd_first = 1'b1;
                  state_in     = ST_READ_B;
               end else begin
                  cmd.load_seed = 1'b1;
               end
            end
         end
         ST_READ_B: begin
            cmd.rd_second = 1'b1;
            cmd.cap_x     = 1'b1;
            state_in      = ST_CAPTURE_Y;
         end
         ST_CAPTURE_Y: begin
            cmd.cap_y = 1'b1;
            state_in  = ST_PREPARE;
         end
         ST_PREPARE: begin
            cmd.prepare = 1'b1;
            state_in    = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.push_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

/* rtl/core/lfg_checker.sv */
// Port-level checker for the generator top level, bound to it below.
`default_nettype none
`include "lagged_fibonacci_generator_top_defines.svh"
module lfg_port_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [lfg_pkg::SEED_W-1:0]     req_tdata,
   input wire logic                           req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [lfg_pkg::MOD_W-1:0]      rsp_tdata,
   input wire logic                           csr_wr_en,
   input wire logic [lfg_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [lfg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfg_pkg::*;

   `LFG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result transaction changed")
   `LFG_ASSERT_NEXT(a_load_one_cycle, req_tvalid && req_tready && (req_tuser == FUNC_LOAD), req_tready, "load did not finish in one cycle")
   `LFG_ASSERT_NEXT(a_gen_busy, req_tvalid && req_tready && (req_tuser == FUNC_GENERATE), !req_tready, "generate did not hold off the next transaction")
   `LFG_ASSERT_AFTER_RESET(a_reset_idle, req_tready && !rsp_tvalid, "block not idle after reset")

endmodule

bind lagged_fibonacci_generator_top lfg_port_checker u_lfg_checker (.*);
`default_nettype wire
